// ----- src/srf_pkg.sv -----
// ----------------------------------------------------------------------------
// srf_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 3;

	// Smallest frame able to hold its fixed fields: two start bytes, version,
	// two length bytes, two checksum bytes, two end bytes.
	localparam logic [BYTE_W-1:0] FIXED_BYTES = 8'd9;
	// Reported as ack code when the offset lies beyond the frame.
	localparam logic [BYTE_W-1:0] NO_ACK      = 8'hFF;

	// Configuration register indexes
	localparam logic [INDEX_W-1:0] REG_START_FIRST  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_START_SECOND = 3'd1;
	localparam logic [INDEX_W-1:0] REG_END_FIRST    = 3'd2;
	localparam logic [INDEX_W-1:0] REG_END_SECOND   = 3'd3;
	localparam logic [INDEX_W-1:0] REG_VERSION      = 3'd4;
	localparam logic [INDEX_W-1:0] REG_MIN_LENGTH   = 3'd5;
	localparam logic [INDEX_W-1:0] REG_ACK_OFFSET   = 3'd6;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte_first;
		logic [BYTE_W-1:0] start_byte_second;
		logic [BYTE_W-1:0] end_byte_first;
		logic [BYTE_W-1:0] end_byte_second;
		logic [BYTE_W-1:0] version_byte;
		logic [BYTE_W-1:0] min_length;
		logic [BYTE_W-1:0] ack_offset;
	} srf_cfg_t;

	typedef struct packed {
		logic              frame_valid;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] ack_code;
		logic              bad_frame;
	} srf_result_t;

	typedef enum logic [9:0] {
		PH_HUNT1   = 10'b00_0000_0001,
		PH_HUNT2   = 10'b00_0000_0010,
		PH_VER     = 10'b00_0000_0100,
		PH_LENLO   = 10'b00_0000_1000,
		PH_LENHI   = 10'b00_0001_0000,
		PH_PAYLOAD = 10'b00_0010_0000,
		PH_CHKLO   = 10'b00_0100_0000,
		PH_CHKHI   = 10'b00_1000_0000,
		PH_END1    = 10'b01_0000_0000,
		PH_END2    = 10'b10_0000_0000
	} srf_phase_t;

endpackage

`default_nettype wire

// ----- src/srf_byte_if.sv -----
// ----------------------------------------------------------------------------
// srf_byte_if
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface srf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/srf_result_if.sv -----
// ----------------------------------------------------------------------------
// srf_result_if
// Valid/ready channel carrying one deframer result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface srf_result_if;
	logic       valid;
	logic       ready;
	logic       frame_valid;
	logic [7:0] frame_length;
	logic [7:0] ack_code;
	logic       bad_frame;

	modport source (output valid, output frame_valid, output frame_length,
		output ack_code, output bad_frame, input ready);
	modport sink (input valid, input frame_valid, input frame_length,
		input ack_code, input bad_frame, output ready);
endinterface

`default_nettype wire

// ----- src/srf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// srf_cfg_regs
// Configuration register file: write-only, one register per index.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_cfg_regs (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               wr_en,
	input  wire  [srf_pkg::INDEX_W-1:0]       wr_index,
	input  wire  [srf_pkg::BYTE_W-1:0]        wr_data,
	output srf_pkg::srf_cfg_t                 cfg
);
	import srf_pkg::*;

	srf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{start_byte_first: '0, start_byte_second: '0,
				end_byte_first: '0, end_byte_second: '0, version_byte: '0,
				min_length: FIXED_BYTES, ack_offset: '0};
		end else if (wr_en) begin
			case (wr_index)
				REG_START_FIRST:  cfg_q.start_byte_first  <= wr_data;
				REG_START_SECOND: cfg_q.start_byte_second <= wr_data;
				REG_END_FIRST:    cfg_q.end_byte_first    <= wr_data;
				REG_END_SECOND:   cfg_q.end_byte_second   <= wr_data;
				REG_VERSION:      cfg_q.version_byte      <= wr_data;
				REG_MIN_LENGTH:   cfg_q.min_length        <= wr_data;
				REG_ACK_OFFSET:   cfg_q.ack_offset        <= wr_data;
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- src/srf_deframer.sv -----
// ----------------------------------------------------------------------------
// srf_deframer
// Frame state machine: updates the frame state on each stepped byte and
// produces that byte's result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_deframer #(
	parameter int unsigned MAX_FRAME = 255
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               step,
	input  wire  [srf_pkg::BYTE_W-1:0]        rx_byte,
	input  srf_pkg::srf_cfg_t                 cfg,
	output srf_pkg::srf_result_t              result
);
	import srf_pkg::*;

	localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_FRAME);

	srf_phase_t        phase_q, phase_d;
	logic [BYTE_W-1:0] index_q, index_d;
	logic [BYTE_W-1:0] length_q, length_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] chk_q, chk_d;
	logic [BYTE_W-1:0] ack_q, ack_d;
	logic [BYTE_W-1:0] min_len;
	logic [BYTE_W-1:0] index_inc;
	logic [BYTE_W-1:0] start_ack;

	assign min_len   = (cfg.min_length < FIXED_BYTES) ? FIXED_BYTES : cfg.min_length;
	assign index_inc = index_q + 8'd1;
	assign start_ack = (cfg.ack_offset == '0) ? rx_byte : NO_ACK;

	always_comb begin
		phase_d  = phase_q;
		index_d  = index_q;
		length_d = length_q;
		sum_d    = sum_q;
		chk_d    = chk_q;
		ack_d    = ack_q;
		result   = '0;

		if (phase_q != PH_HUNT1) begin
			index_d = index_inc;
			if (index_inc == cfg.ack_offset)
				ack_d = rx_byte;
		end

		case (phase_q)
			PH_HUNT2: begin
				if (rx_byte == cfg.start_byte_second) begin
					phase_d = PH_VER;
				end else if (rx_byte == cfg.start_byte_first) begin
					// restart the candidate at this byte
					phase_d  = PH_HUNT2;
					index_d  = '0;
					sum_d    = '0;
					length_d = '0;
					ack_d    = start_ack;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
			PH_VER: begin
				if (rx_byte == cfg.version_byte) begin
					sum_d   = rx_byte;
					phase_d = PH_LENLO;
				end else begin
					result.bad_frame = 1'b1;
					phase_d          = PH_HUNT1;
				end
			end
			PH_LENLO: begin
				length_d = rx_byte;
				sum_d    = sum_q + rx_byte;
				phase_d  = PH_LENHI;
			end
			PH_LENHI: begin
				sum_d = sum_q + rx_byte;
				// any nonzero high byte puts the length beyond the largest frame
				if (rx_byte != '0 || length_q < min_len || length_q > MaxLen) begin
					result.bad_frame = 1'b1;
					phase_d          = PH_HUNT1;
				end else if (length_q == FIXED_BYTES) begin
					phase_d = PH_CHKLO;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_d = sum_q + rx_byte;
				if ({1'b0, index_inc} + 9'd5 >= {1'b0, length_q})
					phase_d = PH_CHKLO;
			end
			PH_CHKLO: begin
				chk_d   = rx_byte;
				phase_d = PH_CHKHI;
			end
			PH_CHKHI: begin
				phase_d = PH_END1;
			end
			PH_END1: begin
				if (rx_byte == cfg.end_byte_first) begin
					phase_d = PH_END2;
				end else begin
					result.bad_frame = 1'b1;
					phase_d          = PH_HUNT1;
				end
			end
			PH_END2: begin
				if (rx_byte == cfg.end_byte_second && sum_q == chk_q) begin
					result.frame_valid  = 1'b1;
					result.frame_length = length_q;
					result.ack_code     = ack_d;
				end else begin
					result.bad_frame = 1'b1;
				end
				phase_d = PH_HUNT1;
			end
			default: begin
				if (rx_byte == cfg.start_byte_first) begin
					phase_d  = PH_HUNT2;
					index_d  = '0;
					sum_d    = '0;
					length_d = '0;
					ack_d    = start_ack;
				end else begin
					phase_d = PH_HUNT1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT1;
			index_q  <= '0;
			length_q <= '0;
			sum_q    <= '0;
			chk_q    <= '0;
			ack_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			index_q  <= index_d;
			length_q <= length_d;
			sum_q    <= sum_d;
			chk_q    <= chk_d;
			ack_q    <= ack_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/serial_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_core
// Byte-serial deframer: start marker hunt, version, length, checksum and end
// marker checks, one result per received byte.
// ----------------------------------------------------------------------------
//
//  Port      Dir    Handshake        Content
//  rx        in     valid/ready      rx_byte, one serial byte per item
//  res       out    valid/ready      frame_valid, frame_length, ack_code,
//                                    bad_frame, one result per byte
//  wr_*      in     wr_en strobe     configuration write, index and data
//
//  Throughput is one byte per cycle while res is not stalled; the result
//  passes through the input register, then the result register.
//  The frame state advances as a byte moves from the input register into
//  the result register, so a stalled result stalls the state as well.
//  Input is refused only while both registers are full and res is stalled.
//  Reset clears the frame state to hunting and loads register defaults;
//  no clearing pass is needed.
//
`default_nettype none

module serial_frame_receiver_core #(
	parameter int unsigned MAX_FRAME = 255
) (
	input  wire                          clk,
	input  wire                          arst_n,
	srf_byte_if.sink                     rx,
	srf_result_if.source                 res,
	input  wire                          wr_en,
	input  wire  [srf_pkg::INDEX_W-1:0]  wr_index,
	input  wire  [srf_pkg::BYTE_W-1:0]   wr_data
);
	import srf_pkg::*;

	srf_cfg_t          cfg;
	srf_result_t       result;
	srf_result_t       result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv_s2;

	srf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	srf_deframer #(
		.MAX_FRAME (MAX_FRAME)
	) u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s2),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign adv_s2   = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rx.ready)
				valid_s1 <= rx.valid;
			if (adv_s2)
				valid_s2 <= 1'b1;
			else if (res.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
		if (adv_s2)
			result_s2 <= result;
	end

	assign res.valid        = valid_s2;
	assign res.frame_valid  = result_s2.frame_valid;
	assign res.frame_length = result_s2.frame_length;
	assign res.ack_code     = result_s2.ack_code;
	assign res.bad_frame    = result_s2.bad_frame;

	// Input backpressure only when the result register is held by the sink
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s2 && !res.ready))
		else $error("input refused without a stalled result");

	a_good_xor_bad: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.frame_valid && res.bad_frame))
		else $error("result flags both good and bad frame");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.frame_valid) |-> (res.frame_length == '0 && res.ack_code == '0))
		else $error("length or ack code set without a good frame");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.frame_valid) |->
			(res.frame_length >= FIXED_BYTES
			&& {24'd0, res.frame_length} <= 32'(MAX_FRAME)))
		else $error("good frame length out of range");

endmodule

`default_nettype wire
